// ===== rtl/core/rspe_pkg.sv =====
package rspe_pkg;

    localparam int MAX_PARITY_DEF = 40;
    localparam logic [5:0] PARITY_COUNT_RESET = 6'd7;
    localparam logic [7:0] GF_POLY_LOW = 8'h1D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_end;
    } rspe_in_t;

    typedef struct packed {
        logic [7:0] parity_byte;
        logic       last_parity;
    } rspe_out_t;

    typedef struct packed {
        logic init;
        logic gen_step;
        logic advance;
        logic load;
        logic shift;
    } rspe_ctrl_t;

    function automatic logic [7:0] gf_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY_LOW : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

// ===== rtl/core/rspe_cell.sv =====
module rspe_cell
    import rspe_pkg::*;
(
    input  logic       aclk,
    input  rspe_ctrl_t ctrl,
    input  logic [7:0] feedback,
    input  logic [7:0] root,
    input  logic [7:0] rem_up,
    input  logic [7:0] out_up,
    input  logic [7:0] coef_up,
    output logic [7:0] rem_q,
    output logic [7:0] out_q,
    output logic [7:0] coef_q
);

    logic [7:0] rem_reg;
    logic [7:0] out_reg;
    logic [7:0] coef_reg;
    logic [7:0] rem_next;

    assign rem_next = rem_up ^ gf_mul(coef_reg, feedback);

    always_ff @(posedge aclk) begin
        if (ctrl.init) begin
            rem_reg <= '0;
        end else if (ctrl.advance) begin
            rem_reg <= ctrl.load ? 8'h00 : rem_next;
        end

        if (ctrl.load) begin
            out_reg <= rem_next;
        end else if (ctrl.shift) begin
            out_reg <= out_up;
        end

        if (ctrl.init) begin
            coef_reg <= '0;
        end else if (ctrl.gen_step) begin
            coef_reg <= coef_reg ^ gf_mul(coef_up, root);
        end
    end

    assign rem_q  = rem_reg;
    assign out_q  = out_reg;
    assign coef_q = coef_reg;

endmodule

// ===== rtl/core/reed_solomon_parity_encoder.sv =====
// the first parity beat is offered in the cycle after the block-end beat is taken,
// followed by the other parity beats, one per cycle while m_ready is high
// throughput: one data beat per cycle outside generator rebuilds; a block-end beat also
// waits while the previous block's parity beats (other than the last) are being drained
// reset and every parity_count write clear the remainder and rebuild the generator for
// the effective parity count; s_ready stays low until the rebuild is done
module reed_solomon_parity_encoder
    import rspe_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  rspe_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output rspe_out_t  m_data
);

    localparam int CW = $clog2(MAX_PARITY + 1);

    logic [5:0]    pc_reg;
    logic          init_reg;
    logic [CW-1:0] gen_cnt_reg;
    logic [7:0]    root_reg;
    logic [CW-1:0] out_cnt_reg;

    logic [CW-1:0] n_eff;
    logic          out_free;
    logic          in_fire;
    logic          out_fire;
    logic [7:0]    feedback;
    rspe_ctrl_t    ctrl;

    logic [7:0] rem_w  [MAX_PARITY];
    logic [7:0] out_w  [MAX_PARITY];
    logic [7:0] coef_w [MAX_PARITY];

    always_comb begin
        if (pc_reg == 6'd0) begin
            n_eff = CW'(1);
        end else if (int'(pc_reg) > MAX_PARITY) begin
            n_eff = CW'(MAX_PARITY);
        end else begin
            n_eff = CW'(pc_reg);
        end
    end

    assign out_free = (out_cnt_reg == '0) || ((out_cnt_reg == CW'(1)) && m_ready);
    assign s_ready  = !init_reg && (gen_cnt_reg == '0) && (!s_data.block_end || out_free);
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = (out_cnt_reg != '0);
    assign out_fire = m_valid && m_ready;
    assign feedback = s_data.data_byte ^ rem_w[0];

    always_comb begin
        ctrl.init     = init_reg;
        ctrl.gen_step = !init_reg && (gen_cnt_reg != '0);
        ctrl.advance  = in_fire;
        ctrl.load     = in_fire && s_data.block_end;
        ctrl.shift    = out_fire;
    end

    assign m_data.parity_byte = out_w[0];
    assign m_data.last_parity = (out_cnt_reg == CW'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= PARITY_COUNT_RESET;
            init_reg    <= 1'b1;
            gen_cnt_reg <= '0;
            out_cnt_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                pc_reg   <= cfg_wr_data;
                init_reg <= 1'b1;
            end else begin
                init_reg <= 1'b0;
            end

            if (init_reg) begin
                gen_cnt_reg <= n_eff;
            end else if (gen_cnt_reg != '0) begin
                gen_cnt_reg <= gen_cnt_reg - CW'(1);
            end

            if (ctrl.load) begin
                out_cnt_reg <= n_eff;
            end else if (out_fire) begin
                out_cnt_reg <= out_cnt_reg - CW'(1);
            end
        end
    end

    // generator root, alpha^i for derivation step i
    always_ff @(posedge aclk) begin
        if (init_reg) begin
            root_reg <= 8'h01;
        end else if (gen_cnt_reg != '0) begin
            root_reg <= gf_xtime(root_reg);
        end
    end

    for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
        logic [7:0] rem_up;
        logic [7:0] out_up;
        logic [7:0] coef_up;

        if (j == MAX_PARITY - 1) begin : g_top
            assign rem_up = 8'h00;
            assign out_up = 8'h00;
        end else begin : g_mid
            assign rem_up = rem_w[j+1];
            assign out_up = out_w[j+1];
        end

        if (j == 0) begin : g_lead
            assign coef_up = 8'h01;
        end else begin : g_rest
            assign coef_up = coef_w[j-1];
        end

        rspe_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .feedback (feedback),
            .root     (root_reg),
            .rem_up   (rem_up),
            .out_up   (out_up),
            .coef_up  (coef_up),
            .rem_q    (rem_w[j]),
            .out_q    (out_w[j]),
            .coef_q   (coef_w[j])
        );
    end

endmodule
